// ===== src/wrsi_pkg.sv =====
// Shared constants, types and helper functions for the windowed RSI signal unit.
// No dependencies; the other files that use it refer to this package by scoped names.
package wrsi_pkg;

  localparam int PRICE_BITS  = 32;
  localparam int WINDOW_MAX  = 64;
  localparam int HISTORY_MAX = 32;

  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
  localparam int DIFF_W     = PRICE_BITS + 1;
  localparam int SUM_W      = PRICE_BITS + PTR_W;
  localparam int TOT_W      = SUM_W + 1;
  localparam int RSI_W      = 14;
  localparam int POINT_W    = 15;
  localparam int NUM_W      = SUM_W + RSI_W;
  localparam int QCNT_W     = $clog2(RSI_W);
  localparam int HIST_IDX_W = $clog2(HISTORY_MAX);

  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int WLEN_W     = 7;
  localparam int THR_W      = 7;
  localparam int CI_W       = 5;

  localparam logic [RSI_W-1:0]   RSI_FULL   = RSI_W'(10000);
  localparam logic [POINT_W-1:0] POINT_NONE = '1;

  localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(14);
  localparam logic [THR_W-1:0]  UPPER_RESET = THR_W'(70);
  localparam logic [THR_W-1:0]  LOWER_RESET = THR_W'(30);
  localparam logic [CI_W-1:0]   CI_RESET    = '0;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 2'd3;

  typedef struct packed {
    logic                push;
    logic                clear;
    logic [POINT_W-1:0]  buy_mark;
    logic [POINT_W-1:0]  sell_mark;
    logic [CI_W-1:0]     interval;
  } cell_ctl_t;

  typedef struct packed {
    logic buy;
    logic sell;
  } cell_hit_t;

  // 10000 * g as shifts and adds: 10000 = 8192 + 1024 + 512 + 256 + 16
  function automatic logic [NUM_W-1:0] mul_full(input logic [SUM_W-1:0] g);
    logic [NUM_W-1:0] x;
    x = NUM_W'(g);
    return (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4);
  endfunction

  // whole points to hundredths: 100 = 64 + 32 + 4
  function automatic logic [RSI_W-1:0] thr_scale(input logic [THR_W-1:0] t);
    logic [RSI_W-1:0] x;
    x = RSI_W'(t);
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

// ===== src/wrsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/wrsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle: quo = num / den.
// Depends on wrsi_pkg; the quotient must fit in RSI_W bits.
module wrsi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wrsi_pkg::NUM_W-1:0]   num,
  input  logic [wrsi_pkg::TOT_W-1:0]   den,
  output logic [wrsi_pkg::RSI_W-1:0]   quo,
  output logic                         done
);

  logic [wrsi_pkg::NUM_W-1:0]  rem_r;
  logic [wrsi_pkg::NUM_W-1:0]  dsh_r;
  logic [wrsi_pkg::RSI_W-1:0]  quo_r;
  logic [wrsi_pkg::QCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        fits;

  assign fits = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        // align the divisor with the top quotient bit
        dsh_r  <= wrsi_pkg::NUM_W'({den, {(wrsi_pkg::RSI_W-1){1'b0}}});
        quo_r  <= '0;
        cnt_r  <= wrsi_pkg::QCNT_W'(wrsi_pkg::RSI_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[wrsi_pkg::RSI_W-2:0], fits};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== src/wrsi_cell.sv =====
// One cell of the rsi history row: holds one point, shifts it to the next cell
// on a push and flags a match against the buy and sell marks. Depends on wrsi_pkg.
module wrsi_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wrsi_pkg::cell_ctl_t              ctl,
  input  logic [wrsi_pkg::POINT_W-1:0]     prev_val,
  input  logic                             prev_valid,
  input  logic [wrsi_pkg::HIST_IDX_W-1:0]  idx,
  output logic [wrsi_pkg::POINT_W-1:0]     val,
  output logic                             valid,
  output wrsi_pkg::cell_hit_t              hit
);

  logic [wrsi_pkg::POINT_W-1:0] val_r;
  logic                         valid_r;
  wrsi_pkg::cell_hit_t          hit_r;
  logic                         live;

  // searched only inside the crossing interval and never on an undefined point
  assign live = valid_r && (8'(idx) <= 8'(ctl.interval)) && (val_r != wrsi_pkg::POINT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.push) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      val_r <= prev_val;
    end
    hit_r.buy  <= live && (val_r == ctl.buy_mark);
    hit_r.sell <= live && (val_r == ctl.sell_mark);
  end

  assign val   = val_r;
  assign valid = valid_r;
  assign hit   = hit_r;

endmodule

// ===== src/windowed_rsi_threshold_signal_unit.sv =====
// Top level of the windowed RSI threshold signal unit: difference window RAM,
// running sums, serial divider and the history row. Uses wrsi_pkg, wrsi_ram, wrsi_div, wrsi_cell.
//
//  port group   direction  beat contents
//  in_*         slave      in_tdata = close_price; in_tuser = restart
//  out_*        master     out_tdata = rsi_value, buy_signal, sell_signal; out_tuser = rsi_defined
//  cfg_*        write      cfg_addr = register index, cfg_wdata = value
//
// A price that yields a result passes through accept, window update, divider start,
// 14 divider steps plus done (both skipped when both sums are zero), history push,
// match scan and decision. The serial divider produces one quotient bit per cycle.
// A price that only fills the window passes through accept and window update; a series start is only accepted.
// in_tready is high only while the unit is idle; a held result stalls the decision step.
// rst_n is synchronous; the difference RAM needs no clearing pass after reset.
module windowed_rsi_threshold_signal_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] close_price
  input  logic                            in_tuser,   // [0] restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [13:0] rsi_value, [14] buy, [15] sell
  output logic                            out_tuser,  // [0] rsi_defined
  input  logic                            cfg_we,
  input  logic [wrsi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wrsi_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;

  logic [2:0] state_r;

  logic [wrsi_pkg::WLEN_W-1:0] wlen_r;
  logic [wrsi_pkg::THR_W-1:0]  upper_r;
  logic [wrsi_pkg::THR_W-1:0]  lower_r;
  logic [wrsi_pkg::CI_W-1:0]   interval_r;

  logic                             open_r;
  logic [wrsi_pkg::PRICE_BITS-1:0]  prev_r;
  logic [wrsi_pkg::FILL_W-1:0]      fill_r;
  logic [wrsi_pkg::PTR_W-1:0]       wpos_r;
  logic [wrsi_pkg::SUM_W-1:0]       gain_r;
  logic [wrsi_pkg::SUM_W-1:0]       loss_r;
  logic [wrsi_pkg::SUM_W-1:0]       gain_nxt;
  logic [wrsi_pkg::SUM_W-1:0]       loss_nxt;
  logic [wrsi_pkg::DIFF_W-1:0]      diff_r;
  logic                             full_r;
  logic                             go_r;
  logic                             defined_r;
  logic [wrsi_pkg::RSI_W-1:0]       rsi_r;
  logic [wrsi_pkg::POINT_W-1:0]     buy_mark_r;
  logic [wrsi_pkg::POINT_W-1:0]     sell_mark_r;

  logic                             out_valid_r;
  logic [wrsi_pkg::RSI_W-1:0]       out_rsi_r;
  logic                             out_def_r;
  logic                             out_buy_r;
  logic                             out_sell_r;

  logic [wrsi_pkg::PRICE_BITS-1:0]  price;
  logic                             in_fire;
  logic                             new_series;
  logic [wrsi_pkg::WLEN_W-1:0]      w_act;
  logic                             up;
  logic [wrsi_pkg::PRICE_BITS-1:0]  mag;
  logic [wrsi_pkg::DIFF_W-1:0]      old_diff;
  logic [wrsi_pkg::TOT_W-1:0]       total;
  logic [wrsi_pkg::RSI_W-1:0]       div_quo;
  logic                             div_done;
  logic                             div_start;
  logic [wrsi_pkg::POINT_W-1:0]     new_point;
  logic                             any_buy;
  logic                             any_sell;
  logic                             buy;
  logic                             sell;
  logic                             out_free;
  wrsi_pkg::cell_ctl_t              ctl;

  assign price      = in_tdata[wrsi_pkg::PRICE_BITS-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign new_series = in_tuser || !open_r;

  // zero acts as one, anything beyond the window depth as the depth
  always_comb begin
    if (wlen_r == '0) begin
      w_act = wrsi_pkg::WLEN_W'(1);
    end else if (wlen_r > wrsi_pkg::WLEN_W'(wrsi_pkg::WINDOW_MAX)) begin
      w_act = wrsi_pkg::WLEN_W'(wrsi_pkg::WINDOW_MAX);
    end else begin
      w_act = wlen_r;
    end
  end

  assign up  = price > prev_r;
  assign mag = up ? (price - prev_r) : (prev_r - price);

  wrsi_ram #(
    .WIDTH (wrsi_pkg::DIFF_W),
    .DEPTH (wrsi_pkg::WINDOW_MAX)
  ) u_window (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (wpos_r),
    .wdata (diff_r),
    .re    (in_fire && !new_series),
    .raddr (wpos_r - w_act[wrsi_pkg::PTR_W-1:0]),
    .rdata (old_diff)
  );

  // retire the oldest difference once the window is full, then add the new one
  always_comb begin
    gain_nxt = gain_r;
    loss_nxt = loss_r;
    if (full_r) begin
      if (old_diff[wrsi_pkg::DIFF_W-1]) begin
        gain_nxt = gain_nxt - wrsi_pkg::SUM_W'(old_diff[wrsi_pkg::PRICE_BITS-1:0]);
      end else begin
        loss_nxt = loss_nxt - wrsi_pkg::SUM_W'(old_diff[wrsi_pkg::PRICE_BITS-1:0]);
      end
    end
    if (diff_r[wrsi_pkg::DIFF_W-1]) begin
      gain_nxt = gain_nxt + wrsi_pkg::SUM_W'(diff_r[wrsi_pkg::PRICE_BITS-1:0]);
    end else begin
      loss_nxt = loss_nxt + wrsi_pkg::SUM_W'(diff_r[wrsi_pkg::PRICE_BITS-1:0]);
    end
  end

  assign total     = wrsi_pkg::TOT_W'(gain_r) + wrsi_pkg::TOT_W'(loss_r);
  assign div_start = (state_r == S_START) && (total != '0);

  wrsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (wrsi_pkg::mul_full(gain_r)),
    .den   (total),
    .quo   (div_quo),
    .done  (div_done)
  );

  // history row
  assign new_point = defined_r ? wrsi_pkg::POINT_W'(rsi_r) : wrsi_pkg::POINT_NONE;

  assign ctl.push      = (state_r == S_PUSH);
  assign ctl.clear     = in_fire && new_series;
  assign ctl.buy_mark  = buy_mark_r;
  assign ctl.sell_mark = sell_mark_r;
  assign ctl.interval  = interval_r;

  logic [wrsi_pkg::POINT_W-1:0] cell_val [wrsi_pkg::HISTORY_MAX];
  logic                         cell_vld [wrsi_pkg::HISTORY_MAX];
  wrsi_pkg::cell_hit_t          cell_hit [wrsi_pkg::HISTORY_MAX];

  for (genvar i = 0; i < wrsi_pkg::HISTORY_MAX; i++) begin : g_hist
    if (i == 0) begin : g_head
      wrsi_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_val   (new_point),
        .prev_valid (1'b1),
        .idx        (wrsi_pkg::HIST_IDX_W'(i)),
        .val        (cell_val[i]),
        .valid      (cell_vld[i]),
        .hit        (cell_hit[i])
      );
    end else begin : g_body
      wrsi_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_val   (cell_val[i-1]),
        .prev_valid (cell_vld[i-1]),
        .idx        (wrsi_pkg::HIST_IDX_W'(i)),
        .val        (cell_val[i]),
        .valid      (cell_vld[i]),
        .hit        (cell_hit[i])
      );
    end
  end

  always_comb begin
    any_buy  = 1'b0;
    any_sell = 1'b0;
    for (int i = 0; i < wrsi_pkg::HISTORY_MAX; i++) begin
      any_buy  = any_buy  | cell_hit[i].buy;
      any_sell = any_sell | cell_hit[i].sell;
    end
  end

  assign buy  = defined_r && (rsi_r < wrsi_pkg::thr_scale(lower_r)) && !any_buy;
  assign sell = defined_r && (rsi_r > wrsi_pkg::thr_scale(upper_r)) && !any_sell;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= wrsi_pkg::WLEN_RESET;
      upper_r     <= wrsi_pkg::UPPER_RESET;
      lower_r     <= wrsi_pkg::LOWER_RESET;
      interval_r  <= wrsi_pkg::CI_RESET;
      open_r      <= 1'b0;
      prev_r      <= '0;
      fill_r      <= '0;
      wpos_r      <= '0;
      gain_r      <= '0;
      loss_r      <= '0;
      buy_mark_r  <= wrsi_pkg::POINT_NONE;
      sell_mark_r <= wrsi_pkg::POINT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            prev_r <= price;
            if (new_series) begin
              // store the price only and open a fresh series
              open_r <= 1'b1;
              fill_r <= '0;
              wpos_r <= '0;
              gain_r <= '0;
              loss_r <= '0;
            end else begin
              diff_r  <= {up, mag};
              full_r  <= fill_r >= wrsi_pkg::FILL_W'(w_act);
              go_r    <= ({1'b0, fill_r} + 1'b1) >= (wrsi_pkg::FILL_W + 1)'(w_act);
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          gain_r <= gain_nxt;
          loss_r <= loss_nxt;
          wpos_r <= wpos_r + 1'b1;
          if (!full_r) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= go_r ? S_START : S_IDLE;
        end
        S_START: begin
          defined_r <= total != '0;
          rsi_r     <= '0;
          state_r   <= (total != '0) ? S_DIV : S_PUSH;
        end
        S_DIV: begin
          if (div_done) begin
            rsi_r   <= div_quo;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rsi_r   <= rsi_r;
            out_def_r   <= defined_r;
            out_buy_r   <= buy;
            out_sell_r  <= sell;
            if (buy) begin
              buy_mark_r <= wrsi_pkg::POINT_W'(rsi_r);
            end
            if (sell) begin
              sell_mark_r <= wrsi_pkg::POINT_W'(rsi_r);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        unique case (cfg_addr)
          wrsi_pkg::REG_WINDOW: begin
            wlen_r <= cfg_wdata[wrsi_pkg::WLEN_W-1:0];
            open_r <= 1'b0;
          end
          wrsi_pkg::REG_UPPER:    upper_r    <= cfg_wdata[wrsi_pkg::THR_W-1:0];
          wrsi_pkg::REG_LOWER:    lower_r    <= cfg_wdata[wrsi_pkg::THR_W-1:0];
          wrsi_pkg::REG_INTERVAL: interval_r <= cfg_wdata[wrsi_pkg::CI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sell_r, out_buy_r, out_rsi_r};
  assign out_tuser  = out_def_r;

endmodule

// ===== src/wrsi_chk.sv =====
// Port-level checker for the windowed RSI threshold signal unit, bound to the top level.
// Depends on wrsi_pkg for the full-scale rsi constant.
module wrsi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:0] <= wrsi_pkg::RSI_FULL)
    else $error("rsi value above full scale");

  a_undef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("undefined rsi carries a value or a signal");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind windowed_rsi_threshold_signal_unit wrsi_chk u_wrsi_chk (.*);
